// ----- rtl/gell_mann_basis_expansion_macros.svh -----
// Assertion macros used by gmbe_dpath to check its own logic.
`ifndef GELL_MANN_BASIS_EXPANSION_MACROS_SVH
`define GELL_MANN_BASIS_EXPANSION_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GMBE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gmbe assertion failed");

// Next-cycle implication, checked outside reset.
`define GMBE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gmbe assertion failed");

`endif

// ----- rtl/gmbe_pkg.sv -----
`default_nettype none
package gmbe_pkg;

    localparam int MAX_DIM = 8;
    localparam int SLOTS = 63;
    localparam logic [5:0] LAST_SLOT = 6'(SLOTS - 1);

    localparam logic [1:0] K_ENTRY  = 2'd0;
    localparam logic [1:0] K_ROWEND = 2'd1;
    localparam logic [1:0] K_FINISH = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [31:0] entry_re;
        logic signed [31:0] entry_im;
    } t_in_item;

    typedef struct packed {
        logic [5:0]         basis_index;
        logic signed [31:0] coeff_re;
        logic signed [31:0] coeff_im;
        logic               last;
    } t_out_item;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_PREP,
        CMD_LO_RE,
        CMD_HI_RE,
        CMD_LO_IM,
        CMD_HI_IM,
        CMD_RES,
        CMD_RD0,
        CMD_WR0,
        CMD_WR1,
        CMD_SETSUM,
        CMD_SUM,
        CMD_SETROW,
        CMD_ROWEND,
        CMD_SC_START,
        CMD_SC_RD,
        CMD_SC_TAKE,
        CMD_SC_SKIP,
        CMD_FLUSH,
        CMD_CLEAR
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic load;
    } t_ctl;

    typedef struct packed {
        logic [1:0] kind;
        logic       in_range;
        logic       is_diag;
        logic       col_zero;
        logic       row_zero;
        logic       seen;
        logic       qualify;
        logic       scan_last;
        logic       pend_v;
        logic       out_free;
    } t_sts;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bval;
        n = v;
        res = 64'd0;
        bval = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (n >= res + bval) begin
                n = n - (res + bval);
                res = (res >> 1) + bval;
            end else begin
                res = res >> 1;
            end
            bval = bval >> 2;
        end
        return res;
    endfunction

    localparam logic [63:0] Q62 = 64'h4000_0000_0000_0000;
    localparam logic [29:0] C_M2  = 30'((isqrt64(Q62 / 2) + 64'd1) >> 1);
    localparam logic [29:0] C_M6  = 30'((isqrt64(Q62 / 6) + 64'd1) >> 1);
    localparam logic [29:0] C_M12 = 30'((isqrt64(Q62 / 12) + 64'd1) >> 1);
    localparam logic [29:0] C_M20 = 30'((isqrt64(Q62 / 20) + 64'd1) >> 1);
    localparam logic [29:0] C_M30 = 30'((isqrt64(Q62 / 30) + 64'd1) >> 1);
    localparam logic [29:0] C_M42 = 30'((isqrt64(Q62 / 42) + 64'd1) >> 1);
    localparam logic [29:0] C_M56 = 30'((isqrt64(Q62 / 56) + 64'd1) >> 1);

    // Scale factor 1/sqrt(k(k+1)) in unsigned Q0.30.
    function automatic logic [29:0] diag_coef(input logic [2:0] k);
        logic [29:0] c;
        case (k)
            3'd2:    c = C_M6;
            3'd3:    c = C_M12;
            3'd4:    c = C_M20;
            3'd5:    c = C_M30;
            3'd6:    c = C_M42;
            3'd7:    c = C_M56;
            default: c = C_M2;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/gmbe_ctrl.sv -----
`default_nettype none
module gmbe_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire gmbe_pkg::t_sts i_sts,
    output gmbe_pkg::t_ctl     o_ctl,
    output logic               o_busy
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_LO_RE,
        S_HI_RE,
        S_LO_IM,
        S_HI_IM,
        S_RES,
        S_RD0,
        S_WR0,
        S_WR1,
        S_SETSUM,
        S_SETROW,
        S_SC_RD,
        S_SC_CHK,
        S_SC_END
    } t_state;

    t_state r_state;
    t_state n_state;
    gmbe_pkg::t_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd = gmbe_pkg::CMD_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                unique case (i_sts.kind)
                    gmbe_pkg::K_ENTRY: begin
                        if (i_sts.in_range) begin
                            if (i_sts.is_diag && i_sts.col_zero) begin
                                cmd = gmbe_pkg::CMD_SUM;
                            end else begin
                                cmd = gmbe_pkg::CMD_PREP;
                                n_state = S_LO_RE;
                            end
                        end
                    end
                    gmbe_pkg::K_ROWEND: begin
                        if (i_sts.in_range) begin
                            if (!i_sts.seen && !i_sts.row_zero) begin
                                cmd = gmbe_pkg::CMD_PREP;
                                n_state = S_LO_RE;
                            end else begin
                                cmd = gmbe_pkg::CMD_ROWEND;
                            end
                        end
                    end
                    gmbe_pkg::K_FINISH: begin
                        cmd = gmbe_pkg::CMD_SC_START;
                        n_state = S_SC_RD;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_LO_RE: begin
                cmd = gmbe_pkg::CMD_LO_RE;
                n_state = S_HI_RE;
            end
            S_HI_RE: begin
                cmd = gmbe_pkg::CMD_HI_RE;
                n_state = S_LO_IM;
            end
            S_LO_IM: begin
                cmd = gmbe_pkg::CMD_LO_IM;
                n_state = S_HI_IM;
            end
            S_HI_IM: begin
                cmd = gmbe_pkg::CMD_HI_IM;
                n_state = S_RES;
            end
            S_RES: begin
                cmd = gmbe_pkg::CMD_RES;
                if (i_sts.kind == gmbe_pkg::K_ROWEND) begin
                    n_state = S_SETROW;
                end else if (i_sts.is_diag) begin
                    n_state = S_SETSUM;
                end else begin
                    n_state = S_RD0;
                end
            end
            S_RD0: begin
                cmd = gmbe_pkg::CMD_RD0;
                n_state = S_WR0;
            end
            S_WR0: begin
                cmd = gmbe_pkg::CMD_WR0;
                n_state = S_WR1;
            end
            S_WR1: begin
                cmd = gmbe_pkg::CMD_WR1;
                n_state = S_IDLE;
            end
            S_SETSUM: begin
                cmd = gmbe_pkg::CMD_SETSUM;
                n_state = S_IDLE;
            end
            S_SETROW: begin
                cmd = gmbe_pkg::CMD_SETROW;
                n_state = S_IDLE;
            end
            S_SC_RD: begin
                cmd = gmbe_pkg::CMD_SC_RD;
                n_state = S_SC_CHK;
            end
            S_SC_CHK: begin
                if (i_sts.qualify && i_sts.pend_v && !i_sts.out_free) begin
                    cmd = gmbe_pkg::CMD_NOP;
                end else begin
                    cmd = i_sts.qualify ? gmbe_pkg::CMD_SC_TAKE : gmbe_pkg::CMD_SC_SKIP;
                    n_state = i_sts.scan_last ? S_SC_END : S_SC_RD;
                end
            end
            S_SC_END: begin
                if (!i_sts.pend_v) begin
                    cmd = gmbe_pkg::CMD_CLEAR;
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    cmd = gmbe_pkg::CMD_FLUSH;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_ctl.cmd = cmd;
    assign o_ctl.load = (r_state == S_IDLE) && i_in_valid;

endmodule
`default_nettype wire

// ----- rtl/gmbe_dpath.sv -----
`default_nettype none
`include "gell_mann_basis_expansion_macros.svh"
module gmbe_dpath (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire gmbe_pkg::t_ctl      i_ctl,
    input  wire gmbe_pkg::t_in_item  i_in_item,
    input  wire logic                i_cfg_we,
    input  wire logic [3:0]          i_cfg_data,
    input  wire logic                i_out_stall,
    output gmbe_pkg::t_sts           o_sts,
    output logic                     o_out_valid,
    output gmbe_pkg::t_out_item      o_out_item
);

    function automatic logic signed [31:0] sat32(input logic signed [37:0] x);
        logic signed [31:0] y;
        if (x > 38'sd2147483647) begin
            y = 32'sh7fff_ffff;
        end else if (x < -38'sd2147483648) begin
            y = 32'sh8000_0000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    logic [3:0]               r_dim;
    gmbe_pkg::t_in_item       r_item;
    logic signed [35:0]       r_op_re;
    logic signed [35:0]       r_op_im;
    logic [29:0]              r_coef;
    logic                     r_neg;
    logic [65:0]              r_acc;
    logic signed [36:0]       r_s_re;
    logic signed [36:0]       r_s_im;
    logic [63:0]              r_mem [gmbe_pkg::SLOTS];
    logic [gmbe_pkg::SLOTS-1:0] r_mark;
    logic [63:0]              r_rd;
    logic                     r_rd_mark;
    logic signed [31:0]       r_sum_re;
    logic signed [31:0]       r_sum_im;
    logic                     r_seen;
    logic [5:0]               r_scan;
    gmbe_pkg::t_out_item      r_pend;
    logic                     r_pend_v;
    gmbe_pkg::t_out_item      r_out;
    logic                     r_out_valid;

    logic [3:0]               dim_n;
    logic [6:0]               dbase;
    logic [5:0]               slot_d;
    logic [2:0]               pa;
    logic [2:0]               pb;
    logic [6:0]               p_full;
    logic [5:0]               slot_p;
    logic [5:0]               slot_p1;
    logic signed [35:0]       kv_re;
    logic signed [35:0]       kv_im;
    logic signed [35:0]       op_sel;
    logic [35:0]              mag_full;
    logic [34:0]              mag;
    logic [47:0]              lo_prod;
    logic [46:0]              hi_prod;
    logic signed [36:0]       scaled;
    logic signed [31:0]       old_re;
    logic signed [31:0]       old_im;
    logic signed [36:0]       t1_re;
    logic signed [36:0]       t1_im;
    logic                     mem_we;
    logic [5:0]               mem_wa;
    logic [63:0]              mem_wd;
    logic                     mem_re;
    logic [5:0]               mem_ra;
    logic                     push;
    logic                     push_last;
    logic                     clear_run;
    logic                     out_free;
    logic                     is_cmd_mul;

    assign dim_n = (r_dim < 4'd2) ? 4'd2 :
                   (r_dim > 4'(gmbe_pkg::MAX_DIM)) ? 4'(gmbe_pkg::MAX_DIM) : r_dim;
    assign dbase = 7'(dim_n) * (7'(dim_n) - 7'd1);
    assign slot_d = 6'(dbase + 7'(r_item.row) - 7'd1);
    assign pa = (r_item.row < r_item.col) ? r_item.row : r_item.col;
    assign pb = (r_item.row < r_item.col) ? r_item.col : r_item.row;
    assign p_full = 7'(pa * (7'({dim_n, 1'b0}) - 7'd1 - 7'(pa)))
                    + 7'({(pb - pa - 3'd1), 1'b0});
    assign slot_p = p_full[5:0];
    assign slot_p1 = slot_p + 6'd1;

    assign kv_re = 36'($signed({1'b0, r_item.col})) * 36'(r_item.entry_re);
    assign kv_im = 36'($signed({1'b0, r_item.col})) * 36'(r_item.entry_im);

    assign is_cmd_mul = (i_ctl.cmd == gmbe_pkg::CMD_LO_IM) || (i_ctl.cmd == gmbe_pkg::CMD_HI_IM);
    assign op_sel = is_cmd_mul ? r_op_im : r_op_re;
    assign mag_full = op_sel[35] ? 36'(-op_sel) : 36'(op_sel);
    assign mag = mag_full[34:0];
    assign lo_prod = 48'(mag[17:0]) * 48'(r_coef);
    assign hi_prod = 47'(mag[34:18]) * 47'(r_coef);
    assign scaled = r_neg ? -$signed({1'b0, r_acc[65:30]}) : $signed({1'b0, r_acc[65:30]});

    assign old_re = r_rd_mark ? $signed(r_rd[63:32]) : 32'sd0;
    assign old_im = r_rd_mark ? $signed(r_rd[31:0]) : 32'sd0;
    assign t1_re = (r_item.row < r_item.col) ? -r_s_im : r_s_im;
    assign t1_im = (r_item.row < r_item.col) ? r_s_re : -r_s_re;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = slot_p;
        mem_wd = {sat32(38'(r_s_re)), sat32(38'(r_s_im))};
        mem_re = 1'b0;
        mem_ra = slot_p;
        case (i_ctl.cmd)
            gmbe_pkg::CMD_RD0: begin
                mem_re = 1'b1;
            end
            gmbe_pkg::CMD_WR0: begin
                mem_we = 1'b1;
                mem_wd = {sat32(38'(old_re) + 38'(r_s_re)), sat32(38'(old_im) + 38'(r_s_im))};
                mem_re = 1'b1;
                mem_ra = slot_p1;
            end
            gmbe_pkg::CMD_WR1: begin
                mem_we = 1'b1;
                mem_wa = slot_p1;
                mem_wd = {sat32(38'(old_re) + 38'(t1_re)), sat32(38'(old_im) + 38'(t1_im))};
            end
            gmbe_pkg::CMD_SETSUM, gmbe_pkg::CMD_SETROW: begin
                mem_we = 1'b1;
                mem_wa = slot_d;
            end
            gmbe_pkg::CMD_SC_RD: begin
                mem_re = 1'b1;
                mem_ra = r_scan;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign push = ((i_ctl.cmd == gmbe_pkg::CMD_SC_TAKE) && r_pend_v)
                  || (i_ctl.cmd == gmbe_pkg::CMD_FLUSH);
    assign push_last = (i_ctl.cmd == gmbe_pkg::CMD_FLUSH);
    assign clear_run = (i_ctl.cmd == gmbe_pkg::CMD_FLUSH) || (i_ctl.cmd == gmbe_pkg::CMD_CLEAR);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_ra];
            r_rd_mark <= r_mark[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_item <= i_in_item;
        end
        case (i_ctl.cmd)
            gmbe_pkg::CMD_PREP: begin
                if (r_item.kind == gmbe_pkg::K_ROWEND) begin
                    r_op_re <= 36'(r_sum_re);
                    r_op_im <= 36'(r_sum_im);
                    r_coef <= gmbe_pkg::diag_coef(r_item.row);
                end else if (r_item.row == r_item.col) begin
                    r_op_re <= 36'(r_sum_re) - kv_re;
                    r_op_im <= 36'(r_sum_im) - kv_im;
                    r_coef <= gmbe_pkg::diag_coef(r_item.col);
                end else begin
                    r_op_re <= 36'(r_item.entry_re);
                    r_op_im <= 36'(r_item.entry_im);
                    r_coef <= gmbe_pkg::C_M2;
                end
            end
            gmbe_pkg::CMD_LO_RE, gmbe_pkg::CMD_LO_IM: begin
                r_acc <= 66'(lo_prod) + 66'h2000_0000;
                r_neg <= op_sel[35];
            end
            gmbe_pkg::CMD_HI_RE, gmbe_pkg::CMD_HI_IM: begin
                r_acc <= r_acc + (66'(hi_prod) << 18);
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
        if (i_ctl.cmd == gmbe_pkg::CMD_LO_IM) begin
            r_s_re <= scaled;
        end
        if (i_ctl.cmd == gmbe_pkg::CMD_RES) begin
            r_s_im <= scaled;
        end
        if (i_ctl.cmd == gmbe_pkg::CMD_SC_TAKE) begin
            r_pend.basis_index <= r_scan;
            r_pend.coeff_re <= $signed(r_rd[63:32]);
            r_pend.coeff_im <= $signed(r_rd[31:0]);
            r_pend.last <= 1'b0;
        end
        if (push) begin
            r_out.basis_index <= r_pend.basis_index;
            r_out.coeff_re <= r_pend.coeff_re;
            r_out.coeff_im <= r_pend.coeff_im;
            r_out.last <= push_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= 4'd8;
            r_mark <= '0;
            r_sum_re <= 32'sd0;
            r_sum_im <= 32'sd0;
            r_seen <= 1'b0;
            r_scan <= 6'd0;
            r_pend_v <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dim <= i_cfg_data;
            end
            if (mem_we) begin
                r_mark[mem_wa] <= 1'b1;
            end
            case (i_ctl.cmd)
                gmbe_pkg::CMD_SUM, gmbe_pkg::CMD_SETSUM: begin
                    r_sum_re <= sat32(38'(r_sum_re) + 38'(r_item.entry_re));
                    r_sum_im <= sat32(38'(r_sum_im) + 38'(r_item.entry_im));
                    r_seen <= 1'b1;
                end
                gmbe_pkg::CMD_ROWEND, gmbe_pkg::CMD_SETROW: begin
                    r_seen <= 1'b0;
                end
                gmbe_pkg::CMD_SC_START: begin
                    r_scan <= 6'd0;
                    r_pend_v <= 1'b0;
                end
                gmbe_pkg::CMD_SC_TAKE: begin
                    r_scan <= r_scan + 6'd1;
                    r_pend_v <= 1'b1;
                end
                gmbe_pkg::CMD_SC_SKIP: begin
                    r_scan <= r_scan + 6'd1;
                end
                default: begin
                    r_seen <= r_seen;
                end
            endcase
            if (clear_run) begin
                r_mark <= '0;
                r_sum_re <= 32'sd0;
                r_sum_im <= 32'sd0;
                r_seen <= 1'b0;
                r_pend_v <= 1'b0;
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.kind = r_item.kind;
    assign o_sts.in_range = (4'(r_item.row) < dim_n) &&
                            ((r_item.kind != gmbe_pkg::K_ENTRY) || (4'(r_item.col) < dim_n));
    assign o_sts.is_diag = (r_item.row == r_item.col);
    assign o_sts.col_zero = (r_item.col == 3'd0);
    assign o_sts.row_zero = (r_item.row == 3'd0);
    assign o_sts.seen = r_seen;
    assign o_sts.qualify = r_rd_mark && (r_rd != 64'd0);
    assign o_sts.scan_last = (r_scan == gmbe_pkg::LAST_SLOT);
    assign o_sts.pend_v = r_pend_v;
    assign o_sts.out_free = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_item = r_out;

    `GMBE_ASSERT_IMPL(a_push_free, push, out_free)
    `GMBE_ASSERT_IMPL(a_out_nonzero, r_out_valid, (r_out.coeff_re != 0) || (r_out.coeff_im != 0))
    `GMBE_ASSERT_IMPL(a_scan_bound, i_ctl.cmd == gmbe_pkg::CMD_SC_RD, r_scan <= gmbe_pkg::LAST_SLOT)
    `GMBE_ASSERT_NEXT(a_flush_clears, i_ctl.cmd == gmbe_pkg::CMD_FLUSH, !r_pend_v && (r_mark == '0))

endmodule
`default_nettype wire

// ----- rtl/gell_mann_basis_expansion.sv -----
// Items are taken one at a time: o_in_stall stays high until the controller is back in
// idle. Off-diagonal entries, later diagonal entries and scaled row ends are scaled and
// stored; plain row ends, first diagonals and ignored items are not scaled.
// Finish reads and checks every store slot in turn and waits on output stalls.
// Each complex scaling uses an 18 by 30 and a 17 by 30 bit partial product per part.
// Synchronous active-low reset sets N to 8, clears marks and sums; no clearing pass.
`default_nettype none
module gell_mann_basis_expansion (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire gmbe_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output gmbe_pkg::t_out_item      o_out_item,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [3:0]          i_cfg_data
);

    gmbe_pkg::t_ctl ctl;
    gmbe_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    gmbe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_ctl      (ctl),
        .o_busy     (o_in_stall)
    );

    gmbe_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

// ----- verif/tb_gell_mann_basis_expansion.sv -----
`default_nettype none
module tb_gell_mann_basis_expansion;
    import gmbe_pkg::*;

    class coeff_scoreboard;
        t_out_item pending[$];
        int errors;
        int seen;
        int dim;
        longint acc_re[SLOTS];
        longint acc_im[SLOTS];
        bit marked[SLOTS];
        longint sum_re;
        longint sum_im;
        bit diag_seen;

        function new();
            errors = 0;
            seen = 0;
            dim = 8;
            wipe();
        endfunction

        function void wipe();
            for (int s = 0; s < SLOTS; s++) begin
                acc_re[s] = 0;
                acc_im[s] = 0;
                marked[s] = 0;
            end
            sum_re = 0;
            sum_im = 0;
            diag_seen = 0;
        endfunction

        function void set_dim(logic [3:0] v);
            dim = (v < 2) ? 2 : (v > MAX_DIM) ? MAX_DIM : int'(v);
        endfunction

        function longint clip(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        function longint root_floor(longint unsigned n);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return longint'(r);
        endfunction

        function longint unsigned inv_root(longint unsigned m);
            return (root_floor(64'h4000_0000_0000_0000 / m) + 1) >> 1;
        endfunction

        function longint rescale(longint x, longint unsigned c);
            longint unsigned mag;
            longint unsigned r;
            mag = (x < 0) ? longint'(0) - x : x;
            r = (mag * c + (64'd1 << 29)) >> 30;
            return (x < 0) ? -longint'(r) : longint'(r);
        endfunction

        function void add_to(int s, longint re, longint im);
            if (s >= SLOTS) return;
            acc_re[s] = clip(acc_re[s] + re);
            acc_im[s] = clip(acc_im[s] + im);
            marked[s] = 1;
        endfunction

        function void put_to(int s, longint re, longint im);
            if (s >= SLOTS) return;
            acc_re[s] = clip(re);
            acc_im[s] = clip(im);
            marked[s] = 1;
        endfunction

        function void note_item(t_in_item it);
            int r, c, a, b, p, base;
            longint vre, vim, sre, sim;
            longint unsigned k;
            t_out_item o;
            r = it.row;
            c = it.col;
            vre = it.entry_re;
            vim = it.entry_im;
            base = dim * (dim - 1);
            if (it.kind == K_ENTRY) begin
                if (r >= dim || c >= dim) return;
                if (r != c) begin
                    a = (r < c) ? r : c;
                    b = (r < c) ? c : r;
                    p = a * (2 * dim - 1 - a) + 2 * (b - a - 1);
                    k = inv_root(2);
                    sre = rescale(vre, k);
                    sim = rescale(vim, k);
                    add_to(p, sre, sim);
                    if (r < c) add_to(p + 1, -sim, sre);
                    else add_to(p + 1, sim, -sre);
                end else begin
                    diag_seen = 1;
                    if (c != 0) begin
                        k = inv_root(c * (c + 1));
                        put_to(base + c - 1, rescale(sum_re - c * vre, k),
                               rescale(sum_im - c * vim, k));
                    end
                    sum_re = clip(sum_re + vre);
                    sum_im = clip(sum_im + vim);
                end
            end else if (it.kind == K_ROWEND) begin
                if (r >= dim) return;
                if (!diag_seen && r != 0) begin
                    k = inv_root(r * (r + 1));
                    put_to(base + r - 1, rescale(sum_re, k), rescale(sum_im, k));
                end
                diag_seen = 0;
            end else if (it.kind == K_FINISH) begin
                int first;
                first = pending.size();
                for (int s = 0; s < SLOTS; s++) begin
                    if (marked[s] && (acc_re[s] != 0 || acc_im[s] != 0)) begin
                        o.basis_index = 6'(s);
                        o.coeff_re = 32'(acc_re[s]);
                        o.coeff_im = 32'(acc_im[s]);
                        o.last = 0;
                        pending.push_back(o);
                    end
                end
                if (pending.size() > first) pending[pending.size() - 1].last = 1;
                wipe();
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            seen++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.basis_index != want.basis_index)
                $display("%0t: basis_index expected %0d actual %0d", $time,
                         want.basis_index, got.basis_index);
            if (got.coeff_re != want.coeff_re)
                $display("%0t: coeff_re expected %h actual %h", $time,
                         want.coeff_re, got.coeff_re);
            if (got.coeff_im != want.coeff_im)
                $display("%0t: coeff_im expected %h actual %h", $time,
                         want.coeff_im, got.coeff_im);
            if (got.last != want.last)
                $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
            if (got != want) errors++;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in_item i_in_item;
    logic o_out_valid;
    logic i_out_stall;
    t_out_item o_out_item;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [3:0] i_cfg_data;

    coeff_scoreboard board;
    int sent;
    int hold_cycles;

    gell_mann_basis_expansion dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #40000000;
        $display("tb_gell_mann_basis_expansion NOT OK");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'(int'($urandom_range(0, 400000)) - 200000);
            default: return $urandom;
        endcase
    endfunction

    // Valid stays high after an accepted transaction unless a gap follows.
    task automatic send_item(logic [1:0] kind, logic [2:0] row, logic [2:0] col,
                             logic [31:0] vre, logic [31:0] vim);
        t_in_item it;
        int g;
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        it.kind = kind;
        it.row = row;
        it.col = col;
        it.entry_re = vre;
        it.entry_im = vim;
        i_in_valid <= 1;
        i_in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_item(it);
        sent++;
    endtask

    task automatic write_dim(logic [3:0] v);
        i_in_valid <= 0;
        @(posedge i_clk);
        while (board.pending.size() != 0 || o_in_stall) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        board.set_dim(v);
    endtask

    // Whole matrix in row order with random sparsity, then finish.
    task automatic send_matrix(int n, int density);
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++)
                if ($urandom_range(0, 99) < density)
                    send_item(K_ENTRY, 3'(r), 3'(c), pick_value(), pick_value());
            send_item(K_ROWEND, 3'(r), 0, $urandom, $urandom);
        end
        send_item(K_FINISH, 3'($urandom), 3'($urandom), $urandom, $urandom);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_result(o_out_item);
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1;
        end else if (!i_rst_n) begin
            i_out_stall <= 0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < 25);
        end
    end

    initial begin
        int n;
        int waited;
        board = new();
        sent = 0;
        hold_cycles = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_in_item = '0;
        i_cfg_valid = 0;
        i_cfg_data = 4'd8;
        i_out_stall = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: extremes, diagonal sums, empty rows, ignored items.
        write_dim(4'd8);
        send_item(K_ENTRY, 0, 7, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(K_ENTRY, 7, 0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(K_ENTRY, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(K_ROWEND, 0, 0, 0, 0);
        send_item(K_ROWEND, 1, 0, 0, 0);
        send_item(K_ENTRY, 2, 2, 32'h8000_0000, 32'h8000_0000);
        send_item(K_ROWEND, 2, 0, 0, 0);
        send_item(K_ENTRY, 7, 7, 32'h0001_0000, 32'hFFFF_0000);
        send_item(K_ROWEND, 7, 0, 0, 0);
        send_item(2'd3, 3, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(K_FINISH, 0, 0, 0, 0);
        send_item(K_FINISH, 0, 0, 0, 0);
        write_dim(4'd2);
        send_item(K_ENTRY, 5, 1, 32'h1234_5678, 32'h1);
        send_item(K_ENTRY, 0, 1, 32'h0001_0000, 0);
        send_item(K_ENTRY, 1, 0, 32'hFFFF_0000, 0);
        send_item(K_ROWEND, 6, 0, 0, 0);
        send_item(K_ENTRY, 1, 1, 32'h0002_0000, 32'h0003_0000);
        send_item(K_ROWEND, 1, 0, 0, 0);
        send_item(K_FINISH, 0, 0, 0, 0);
        write_dim(4'd0);
        send_item(K_ENTRY, 1, 1, 32'h0002_0000, 0);
        send_item(K_FINISH, 0, 0, 0, 0);
        write_dim(4'd15);

        // Long receiver hold while the sender keeps offering a full matrix and more.
        hold_cycles <= 1500;
        send_matrix(8, 60);
        send_item(K_ROWEND, 0, 0, 0, 0);

        while (sent < 120) begin
            n = $urandom_range(0, 9);
            write_dim((n == 0) ? 4'd8 : (n < 3) ? 4'($urandom) : 4'($urandom_range(2, 5)));
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 6))
                    send_item(2'($urandom), 3'($urandom), 3'($urandom), $urandom, $urandom);
                send_item(K_FINISH, 0, 0, 0, 0);
            end else begin
                send_matrix(board.dim, $urandom_range(20, 80));
            end
        end
        i_in_valid <= 0;

        waited = 0;
        while (board.pending.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (300) @(posedge i_clk);
        $display("Sent %0d input items over several dimensions; %0d coefficients checked.",
                 sent, board.seen);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("tb_gell_mann_basis_expansion OK");
        end else begin
            $display("tb_gell_mann_basis_expansion NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire
